// ----- hw/rtl/kbt_pkg.sv -----
// shared types, codes and defaults for the keyed barrier table
// used by kbt_cell and keyed_barrier_table; no dependencies
package kbt_pkg;

    localparam int BARRIERS_DEF   = 16;
    localparam int REQUESTERS_DEF = 32;

    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_WAIT    = 2'd1;
    localparam logic [1:0] MODE_DESTROY = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_BLOCK = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_HIT     = 3'd1;
    localparam logic [2:0] OP_ALLOC   = 3'd2;
    localparam logic [2:0] OP_WAIT    = 3'd3;
    localparam logic [2:0] OP_DESTROY = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic [7:0]         goal;
        logic [4:0]         requester;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic free;
    } scan_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        released;
        logic [31:0] mask;
    } result_t;

endpackage

// ----- hw/rtl/kbt_cell.sv -----
// one barrier entry of the table, plus its stage of the lookup chain
// depends on kbt_pkg
module kbt_cell #(
    parameter int IDX_W      = 4,
    parameter int MASK_W     = 32,
    parameter int CELL_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kbt_pkg::cmd_t        cmd,
    input  logic                 cmd_en,
    input  kbt_pkg::scan_t       scan_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     free_idx_in,
    output kbt_pkg::scan_t       scan_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     free_idx_out,
    output kbt_pkg::result_t     res
);

    logic signed [31:0] key_reg, key_next;
    logic [7:0]         goal_reg, goal_next;
    logic [7:0]         count_reg, count_next;
    logic [15:0]        users_reg, users_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;

    kbt_pkg::scan_t     scan_reg, scan_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               in_use;
    logic               match;
    logic [8:0]         arrive;
    logic               release_now;
    logic [31:0]        req_onehot;
    logic [MASK_W-1:0]  req_bit;

    assign in_use      = (users_reg != 16'd0);
    assign match       = in_use && (key_reg == cmd.key);
    assign arrive      = {1'b0, count_reg} + 9'd1;
    assign release_now = (arrive >= {1'b0, goal_reg});
    assign req_onehot  = 32'd1 << cmd.requester;
    assign req_bit     = req_onehot[MASK_W-1:0];

    // result of the addressed request against this entry
    always_comb
    begin
        res = '0;
        res.status = kbt_pkg::STATUS_DONE;
        if (cmd.op == kbt_pkg::OP_WAIT && in_use)
        begin
            if (release_now)
            begin
                res.released = 1'b1;
                res.mask     = 32'(mask_reg);
            end
            else
            begin
                res.status = kbt_pkg::STATUS_BLOCK;
            end
        end
        else if (cmd.op == kbt_pkg::OP_DESTROY)
        begin
            res.released = 1'b1;
            res.mask     = 32'(mask_reg);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        goal_next  = goal_reg;
        count_next = count_reg;
        users_next = users_reg;
        mask_next  = mask_reg;
        if (cmd_en)
        begin
            case (cmd.op)
                kbt_pkg::OP_HIT:
                begin
                    if (users_reg != 16'hFFFF)
                    begin
                        users_next = users_reg + 16'd1;
                    end
                    goal_next = cmd.goal;
                end
                kbt_pkg::OP_ALLOC:
                begin
                    users_next = 16'd1;
                    key_next   = cmd.key;
                    goal_next  = cmd.goal;
                    count_next = 8'd0;
                    mask_next  = '0;
                end
                kbt_pkg::OP_WAIT:
                begin
                    if (in_use)
                    begin
                        if (release_now)
                        begin
                            mask_next  = '0;
                            count_next = 8'd0;
                        end
                        else
                        begin
                            count_next = arrive[8] ? 8'hFF : arrive[7:0];
                            mask_next  = mask_reg | req_bit;
                        end
                    end
                end
                kbt_pkg::OP_DESTROY:
                begin
                    users_next = 16'd0;
                    mask_next  = '0;
                    count_next = 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // lookup stage: carry the first hit and first free entry down the chain
    always_comb
    begin
        scan_next.valid = scan_in.valid;
        scan_next.hit   = scan_in.hit | match;
        scan_next.free  = scan_in.free | !in_use;
        hit_idx_next    = scan_in.hit ? hit_idx_in : IDX_W'(CELL_INDEX);
        free_idx_next   = scan_in.free ? free_idx_in : IDX_W'(CELL_INDEX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg  <= 8'd0;
            count_reg <= 8'd0;
            users_reg <= 16'd0;
            mask_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            goal_reg  <= goal_next;
            count_reg <= count_next;
            users_reg <= users_next;
            mask_reg  <= mask_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_en && cmd.op == kbt_pkg::OP_ALLOC) |-> !in_use)
        else $error("allocation into an entry in use");

    a_hit_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_en && cmd.op == kbt_pkg::OP_HIT) |-> match)
        else $error("key hit on an entry that does not match");

    a_wait_release: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_en && cmd.op == kbt_pkg::OP_WAIT && in_use && release_now)
        |=> (count_reg == 8'd0 && mask_reg == '0))
        else $error("released barrier not cleared");

endmodule

// ----- hw/rtl/keyed_barrier_table.sv -----
// keyed barrier table: a row of entry cells with a lookup chain and a request sequencer
// depends on kbt_pkg and kbt_cell
// open: the lookup token steps one cell per cycle down the chain, then the open executes;
// wait, destroy and ignored requests execute after acceptance; any execution waits on out_ready
// one request at a time: in_ready stays low until the accepted request executes
// reset: all entries free with zero counts and masks; no clearing pass is needed
module keyed_barrier_table #(
    parameter int BARRIERS   = kbt_pkg::BARRIERS_DEF,
    parameter int REQUESTERS = kbt_pkg::REQUESTERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] key,
    input  logic [7:0]         goal,
    input  logic [3:0]         barrier,
    input  logic [4:0]         requester,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [3:0]         handle,
    output logic               released,
    output logic [31:0]        released_mask
);

    localparam int IDX_W  = (BARRIERS > 1) ? $clog2(BARRIERS) : 1;
    localparam int MASK_W = (REQUESTERS < 32) ? REQUESTERS : 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                scan_start_reg, scan_start_next;

    logic [1:0]          mode_reg;
    logic signed [31:0]  key_reg;
    logic [7:0]          goal_reg;
    logic [3:0]          barrier_reg;
    logic [4:0]          requester_reg;

    logic                hit_reg, free_reg;
    logic [IDX_W-1:0]    hit_idx_reg, free_idx_reg;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg;
    logic [3:0]          handle_reg;
    logic                released_reg;
    logic [31:0]         mask_reg;

    kbt_pkg::scan_t      scan_chain [BARRIERS+1];
    logic [IDX_W-1:0]    hit_chain  [BARRIERS+1];
    logic [IDX_W-1:0]    free_chain [BARRIERS+1];
    kbt_pkg::result_t    cell_res   [BARRIERS];
    logic [BARRIERS-1:0] cell_en;

    kbt_pkg::cmd_t       cmd;
    kbt_pkg::result_t    sel_res;
    logic [IDX_W-1:0]    sel;
    logic [IDX_W+3:0]    barrier_wide;
    logic [IDX_W+3:0]    handle_wide;
    logic                barrier_ok;
    logic                requester_ok;
    logic                accept;
    logic                exec_fire;

    logic [1:0]          res_status;
    logic [3:0]          res_handle;
    logic                res_released;
    logic [31:0]         res_mask;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign barrier_wide = {{IDX_W{1'b0}}, barrier_reg};
    assign barrier_ok   = (32'(barrier_reg) < BARRIERS);
    assign requester_ok = (32'(requester_reg) < REQUESTERS);

    // resolve the pending request into a cell command
    always_comb
    begin
        cmd.op        = kbt_pkg::OP_NONE;
        cmd.key       = key_reg;
        cmd.goal      = goal_reg;
        cmd.requester = requester_reg;
        sel           = barrier_wide[IDX_W-1:0];
        case (mode_reg)
            kbt_pkg::MODE_OPEN:
            begin
                if (hit_reg)
                begin
                    cmd.op = kbt_pkg::OP_HIT;
                    sel    = hit_idx_reg;
                end
                else if (free_reg)
                begin
                    cmd.op = kbt_pkg::OP_ALLOC;
                    sel    = free_idx_reg;
                end
            end
            kbt_pkg::MODE_WAIT:
            begin
                if (barrier_ok && requester_ok)
                begin
                    cmd.op = kbt_pkg::OP_WAIT;
                end
            end
            kbt_pkg::MODE_DESTROY:
            begin
                if (barrier_ok)
                begin
                    cmd.op = kbt_pkg::OP_DESTROY;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sel_res     = cell_res[sel];
    assign handle_wide = {4'd0, sel};

    always_comb
    begin
        res_status   = kbt_pkg::STATUS_DONE;
        res_handle   = 4'd0;
        res_released = 1'b0;
        res_mask     = 32'd0;
        case (cmd.op)
            kbt_pkg::OP_HIT, kbt_pkg::OP_ALLOC:
            begin
                res_handle = handle_wide[3:0];
            end
            kbt_pkg::OP_WAIT, kbt_pkg::OP_DESTROY:
            begin
                res_status   = sel_res.status;
                res_released = sel_res.released;
                res_mask     = sel_res.mask;
            end
            default:
            begin
                if (mode_reg == kbt_pkg::MODE_OPEN)
                begin
                    res_status = kbt_pkg::STATUS_FULL;
                end
            end
        endcase
    end

    // lookup chain
    assign scan_chain[0].valid = scan_start_reg;
    assign scan_chain[0].hit   = 1'b0;
    assign scan_chain[0].free  = 1'b0;
    assign hit_chain[0]        = '0;
    assign free_chain[0]       = '0;

    for (genvar g = 0; g < BARRIERS; g++)
    begin : g_cell
        assign cell_en[g] = exec_fire && (cmd.op != kbt_pkg::OP_NONE)
                            && (sel == IDX_W'(g));

        kbt_cell #(
            .IDX_W      (IDX_W),
            .MASK_W     (MASK_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .cmd_en       (cell_en[g]),
            .scan_in      (scan_chain[g]),
            .hit_idx_in   (hit_chain[g]),
            .free_idx_in  (free_chain[g]),
            .scan_out     (scan_chain[g+1]),
            .hit_idx_out  (hit_chain[g+1]),
            .free_idx_out (free_chain[g+1]),
            .res          (cell_res[g])
        );
    end

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_start_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == kbt_pkg::MODE_OPEN)
                    begin
                        state_next      = S_SCAN;
                        scan_start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_chain[BARRIERS].valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_start_reg <= scan_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            key_reg       <= key;
            goal_reg      <= goal;
            barrier_reg   <= barrier;
            requester_reg <= requester;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        if (state_reg == S_SCAN && scan_chain[BARRIERS].valid)
        begin
            hit_reg      <= scan_chain[BARRIERS].hit;
            free_reg     <= scan_chain[BARRIERS].free;
            hit_idx_reg  <= hit_chain[BARRIERS];
            free_idx_reg <= free_chain[BARRIERS];
        end
        if (exec_fire)
        begin
            status_reg   <= res_status;
            handle_reg   <= res_handle;
            released_reg <= res_released;
            mask_reg     <= res_mask;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign handle        = handle_reg;
    assign released      = released_reg;
    assign released_mask = mask_reg;

    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_en))
        else $error("more than one cell addressed");

    a_scan_time: assert property (@(posedge clk) disable iff (!rst_n)
        scan_start_reg |-> ##BARRIERS scan_chain[BARRIERS].valid)
        else $error("lookup token lost in chain");

    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_chain[BARRIERS].valid |-> (state_reg == S_SCAN))
        else $error("lookup finished outside scan");

    a_release_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && released_reg) |-> (status_reg == kbt_pkg::STATUS_DONE))
        else $error("release reported with blocking status");

endmodule

// ----- dv/keyed_barrier_table_tb.sv -----
// self-checking testbench for keyed_barrier_table: random-gap valid/ready traffic with a
// scoreboard class that predicts open, wait and destroy results from its own barrier table
// depends on kbt_pkg and the keyed_barrier_table rtl
module keyed_barrier_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BARRIERS    = kbt_pkg::BARRIERS_DEF;
    localparam int          MAX_LOGGED  = 10;
    localparam longint      CYCLE_LIMIT = 6_000_000;
    localparam int          REPEAT_N    = 24;
    localparam int          RANDOM_N    = 300;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [15:0] USERS_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle;
        logic        released;
        logic [31:0] mask;
    } barrier_result_t;

    class barrier_scoreboard;
        logic signed [31:0] ent_key [BARRIERS];
        bit [7:0]           ent_goal [BARRIERS];
        bit [7:0]           arrivals [BARRIERS];
        bit [15:0]          users [BARRIERS];
        bit [31:0]          waiters [BARRIERS];
        barrier_result_t    pending_results [$];
        int                 mismatches;
        int                 checked;
        int                 allocs;
        int                 hits;
        int                 fulls;
        int                 releases;
        int                 blocks;

        function new();
            foreach (users[i])
            begin
                ent_key[i]  = '0;
                ent_goal[i] = '0;
                arrivals[i] = '0;
                users[i]    = '0;
                waiters[i]  = '0;
            end
        endfunction

        // returns 1 when the request changes state or reports something
        function bit note_request(logic [1:0] m, logic signed [31:0] k, logic [7:0] g,
                                  logic [3:0] b, logic [4:0] r);
            barrier_result_t res;
            bit              acted;
            int              slot;
            bit [8:0]        next_count;
            res   = '0;
            acted = 1'b1;
            slot  = -1;
            case (m)
                kbt_pkg::MODE_OPEN:
                begin
                    for (int i = 0; i < BARRIERS && slot < 0; i++)
                        if (users[i] != 0 && ent_key[i] == k)
                            slot = i;
                    if (slot >= 0)
                    begin
                        if (users[slot] != USERS_MAX)
                            users[slot] = users[slot] + 16'd1;
                        ent_goal[slot] = g;
                        res.handle     = 4'(slot);
                        hits++;
                    end
                    else
                    begin
                        for (int i = 0; i < BARRIERS && slot < 0; i++)
                            if (users[i] == 0)
                                slot = i;
                        if (slot >= 0)
                        begin
                            users[slot]    = 16'd1;
                            ent_key[slot]  = k;
                            ent_goal[slot] = g;
                            arrivals[slot] = '0;
                            waiters[slot]  = '0;
                            res.handle     = 4'(slot);
                            allocs++;
                        end
                        else
                        begin
                            res.status = kbt_pkg::STATUS_FULL;
                            fulls++;
                        end
                    end
                end
                kbt_pkg::MODE_WAIT:
                begin
                    if (users[b] == 0)
                        acted = 1'b0;
                    else
                    begin
                        next_count = {1'b0, arrivals[b]} + 9'd1;
                        if (next_count >= {1'b0, ent_goal[b]})
                        begin
                            res.released = 1'b1;
                            res.mask     = waiters[b];
                            waiters[b]   = '0;
                            arrivals[b]  = '0;
                            releases++;
                        end
                        else
                        begin
                            arrivals[b] = (next_count > 9'd255) ? 8'hFF : next_count[7:0];
                            waiters[b]  = waiters[b] | (32'd1 << r);
                            res.status  = kbt_pkg::STATUS_BLOCK;
                            blocks++;
                        end
                    end
                end
                kbt_pkg::MODE_DESTROY:
                begin
                    res.released = 1'b1;
                    res.mask     = waiters[b];
                    users[b]     = '0;
                    waiters[b]   = '0;
                    arrivals[b]  = '0;
                end
                default:
                    acted = 1'b0;
            endcase
            pending_results.push_back(res);
            return acted;
        endfunction

        function void flag(string what, barrier_result_t want, barrier_result_t got);
            mismatches++;
            if (mismatches <= MAX_LOGGED)
                $display({"[%0t] %s: expected status %0d handle %0d released %0b mask %h,",
                          " got status %0d handle %0d released %0b mask %h"},
                         $realtime, what, want.status, want.handle, want.released, want.mask,
                         got.status, got.handle, got.released, got.mask);
        endfunction

        function void check_result(barrier_result_t got);
            barrier_result_t want;
            string           bad;
            bad = "";
            if (pending_results.size() == 0)
            begin
                flag("result with no request outstanding", '0, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status)
                bad = {bad, " status"};
            if (got.handle !== want.handle)
                bad = {bad, " handle"};
            if (got.released !== want.released)
                bad = {bad, " released"};
            if (got.mask !== want.mask)
                bad = {bad, " released_mask"};
            if (bad != "")
                flag({"wrong", bad}, want, got);
        endfunction

        function int pick_live();
            int live [$];
            foreach (users[i])
                if (users[i] != 0)
                    live.push_back(i);
            if (live.size() == 0)
                return $urandom_range(0, BARRIERS - 1);
            return live[$urandom_range(0, live.size() - 1)];
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = kbt_pkg::MODE_OPEN;
    logic signed [31:0] key = '0;
    logic [7:0]         goal = '0;
    logic [3:0]         barrier = '0;
    logic [4:0]         requester = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [3:0]         handle;
    logic               released;
    logic [31:0]        released_mask;

    barrier_scoreboard  sb;
    bit                 calm = 1'b0;
    int                 stall_left = 0;
    int                 requests_sent = 0;
    int                 effective_sent = 0;
    longint             cycles = 0;
    logic signed [31:0] key_pool [24];

    keyed_barrier_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .key           (key),
        .goal          (goal),
        .barrier       (barrier),
        .requester     (requester),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .handle        (handle),
        .released      (released),
        .released_mask (released_mask)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [7:0] pick_goal();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(0, 5));
        if (r < 80)
            return 8'($urandom_range(6, 20));
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{status, handle, released, released_mask});
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // valid stays high across back-to-back requests, dropped only ahead of a gap
    task automatic send_request(logic [1:0] m, logic signed [31:0] k, logic [7:0] g,
                                logic [3:0] b, logic [4:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        key       <= k;
        goal      <= g;
        barrier   <= b;
        requester <= r;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        if (sb.note_request(m, k, g, b, r))
            effective_sent++;
    endtask

    task automatic open_key(logic signed [31:0] k, logic [7:0] g);
        send_request(kbt_pkg::MODE_OPEN, k, g, 4'($urandom), 5'($urandom));
    endtask

    task automatic wait_at(logic [3:0] b, logic [4:0] r);
        send_request(kbt_pkg::MODE_WAIT, $urandom, 8'($urandom), b, r);
    endtask

    task automatic destroy_at(logic [3:0] b);
        send_request(kbt_pkg::MODE_DESTROY, $urandom, 8'($urandom), b, 5'($urandom));
    endtask

    task automatic random_request(int destroy_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 32)
        begin
            if ($urandom_range(0, 99) < 85)
                open_key(key_pool[$urandom_range(0, 23)], pick_goal());
            else
                open_key($urandom, pick_goal());
        end
        else if (r < 95 - destroy_pct)
        begin
            if ($urandom_range(0, 99) < 88)
                wait_at(4'(sb.pick_live()), 5'($urandom_range(0, 31)));
            else
                wait_at(4'($urandom), 5'($urandom));
        end
        else if (r < 95)
        begin
            if ($urandom_range(0, 99) < 75)
                destroy_at(4'(sb.pick_live()));
            else
                destroy_at(4'($urandom));
        end
        else
            send_request(MODE_UNUSED, $urandom, 8'($urandom), 4'($urandom), 5'($urandom));
    endtask

    initial
    begin
        sb = new();
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'sh7FFF_FFFF;
        key_pool[1] = 32'sh8000_0000;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: key extremes, goal extremes, block and release, goal lowered under blocked
        // waiters, repeated requester, free-entry wait and destroy, unused mode
        open_key(32'sh7FFF_FFFF, 8'd0);
        open_key(32'sh8000_0000, 8'd255);
        open_key(-32'sd1, 8'd3);
        open_key(32'sh7FFF_FFFF, 8'd2);
        wait_at(4'd0, 5'd31);
        wait_at(4'd0, 5'd0);
        wait_at(4'd2, 5'd5);
        wait_at(4'd2, 5'd5);
        open_key(-32'sd1, 8'd1);
        wait_at(4'd2, 5'd10);
        wait_at(4'd15, 5'd3);
        destroy_at(4'd9);
        wait_at(4'd1, 5'd7);
        wait_at(4'd1, 5'd16);
        destroy_at(4'd1);
        send_request(MODE_UNUSED, -32'sd1, 8'hFF, 4'hF, 5'h1F);
        open_key(32'sh8000_0000, 8'd1);
        wait_at(4'd1, 5'd16);
        destroy_at(4'd0);
        destroy_at(4'd1);
        destroy_at(4'd2);

        // repeated opens of one key on entry 0, then fill the table until it reports full
        calm = 1'b1;
        for (int i = 0; i < REPEAT_N; i++)
            open_key(32'sh1234_5678, 8'd2);
        calm = 1'b0;
        for (int i = 1; i <= BARRIERS; i++)
            open_key(32'sh1234_5678 + i, pick_goal());
        wait_at(4'd0, 5'd9);
        wait_at(4'd0, 5'd4);
        for (int i = 0; i < BARRIERS; i++)
            destroy_at(4'(i));

        // random phases with different destroy pressure; one phase runs without idling
        effective_sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 2);
            while (effective_sent < (phase + 1) * RANDOM_N / 4)
                random_request(phase == 1 ? 20 : (phase == 3 ? 4 : 10));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (BARRIERS + 8) @(posedge clk);

        $display("sent %0d requests, checked %0d results", requests_sent, sb.checked);
        $display("opens allocated %0d hit %0d full %0d, waits released %0d blocked %0d",
                 sb.allocs, sb.hits, sb.fulls, sb.releases, sb.blocks);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatching results", sb.mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
